FILE: sv/ssdm_pkg.sv
package ssdm_pkg;

  localparam int CHAR_W   = 5;
  localparam int STATUS_W = 2;

  localparam int DEF_TRIE_NODES    = 1024;
  localparam int DEF_MAX_WORD_LEN  = 64;
  localparam int DEF_ALPHABET_SIZE = 26;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LONG = 2'd2;

endpackage

FILE: sv/ssdm_ram.sv
module ssdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  clk,
  we,
  waddr,
  wdata,
  re,
  raddr,
  rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             we;
  input  logic [AW-1:0]    waddr;
  input  logic [WIDTH-1:0] wdata;
  input  logic             re;
  input  logic [AW-1:0]    raddr;
  output logic [WIDTH-1:0] rdata;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/stream_suffix_dictionary_matcher.sv
// channel  | signals                          | handshake
// ---------+----------------------------------+---------------------------------
// request  | kind, char_code, word_end        | taken on start && !busy
// result   | matched, status                  | valid for the one cycle done is high
//
// a load letter without word end is answered in the next cycle; busy stays low
// a word end walks S_INS_BUF, then S_INS_SLOT, S_INS_CHK per stored letter, up to a
// full table; an overlong or empty word is answered at once. A query walks S_Q_RING,
// then S_Q_SLOT, S_Q_CHK per trie level (at most MAX_WORD_LEN), stops in S_Q_SLOT
// on a letter outside the alphabet. After rst the TRIE_NODES*ALPHABET_SIZE (26624 by
// default) child slots are cleared, busy high; results cannot be stalled
module stream_suffix_dictionary_matcher #(
  parameter int TRIE_NODES    = ssdm_pkg::DEF_TRIE_NODES,
  parameter int MAX_WORD_LEN  = ssdm_pkg::DEF_MAX_WORD_LEN,
  parameter int ALPHABET_SIZE = ssdm_pkg::DEF_ALPHABET_SIZE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          kind,
  input  logic [ssdm_pkg::CHAR_W-1:0]   char_code,
  input  logic                          word_end,
  output logic                          busy,
  output logic                          done,
  output logic                          matched,
  output logic [ssdm_pkg::STATUS_W-1:0] status
);
  import ssdm_pkg::*;

  localparam int NODE_W      = $clog2(TRIE_NODES);
  localparam int CNT_W       = $clog2(TRIE_NODES + 1);
  localparam int CHILD_DEPTH = TRIE_NODES * ALPHABET_SIZE;
  localparam int SLOT_W      = $clog2(CHILD_DEPTH);
  localparam int LEN_AW      = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int LEN_CW      = $clog2(MAX_WORD_LEN + 1);

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_INS_BUF  = 8'b0000_0100,
    S_INS_SLOT = 8'b0000_1000,
    S_INS_CHK  = 8'b0001_0000,
    S_Q_RING   = 8'b0010_0000,
    S_Q_SLOT   = 8'b0100_0000,
    S_Q_CHK    = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [SLOT_W-1:0] clr_addr, clr_addr_next;
  logic [CNT_W-1:0]  nodes_in_use, nodes_in_use_next;
  logic [LEN_CW-1:0] load_len, load_len_next;
  logic              load_too_long, load_too_long_next;
  logic [LEN_AW-1:0] head, head_next;
  logic [LEN_CW-1:0] fill, fill_next;
  logic [LEN_AW-1:0] k, k_next;
  logic [LEN_AW-1:0] pos, pos_next;
  logic [LEN_CW-1:0] n, n_next;
  logic [NODE_W-1:0] node, node_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic              done_next, matched_next;
  logic [STATUS_W-1:0] status_next;

  logic              buf_we, buf_re;
  logic [LEN_AW-1:0] buf_raddr;
  logic [CHAR_W-1:0] buf_rdata;
  logic              ring_we, ring_re;
  logic [LEN_AW-1:0] ring_raddr;
  logic [CHAR_W-1:0] ring_rdata;
  logic              child_we, child_re;
  logic [SLOT_W-1:0] child_waddr;
  logic [NODE_W:0]   child_wdata, child_rdata;

  logic              acc, sym_ok, fits, store, too_eff, last, alloc;
  logic [LEN_CW-1:0] len_eff, len_m1, n_inc;
  logic [CHAR_W-1:0] sym;
  logic [SLOT_W-1:0] slot_calc;
  logic [NODE_W-1:0] e_child, nchild;
  logic              e_term;
  logic [LEN_AW-1:0] head_inc, pos_dec;

  assign busy    = (state != S_IDLE);
  assign acc     = start && (state == S_IDLE);
  assign sym_ok  = char_code < CHAR_W'(ALPHABET_SIZE);
  assign fits    = load_len < LEN_CW'(MAX_WORD_LEN);
  assign store   = sym_ok && fits;
  assign too_eff = load_too_long || (sym_ok && !fits);
  assign len_eff = load_len + LEN_CW'(store);
  assign len_m1  = len_eff - 1'b1;
  assign n_inc   = n + 1'b1;

  assign sym       = (state == S_INS_SLOT) ? buf_rdata : ring_rdata;
  assign slot_calc = SLOT_W'(node) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(sym);
  assign e_child   = child_rdata[NODE_W-1:0];
  assign e_term    = child_rdata[NODE_W];
  assign alloc     = (e_child == '0);
  assign nchild    = alloc ? nodes_in_use[NODE_W-1:0] : e_child;
  assign last      = (k == '0);
  assign head_inc  = (head == LEN_AW'(MAX_WORD_LEN - 1)) ? '0 : head + 1'b1;
  assign pos_dec   = (pos == '0) ? LEN_AW'(MAX_WORD_LEN - 1) : pos - 1'b1;

  always_comb begin
    state_next         = state;
    clr_addr_next      = clr_addr;
    nodes_in_use_next  = nodes_in_use;
    load_len_next      = load_len;
    load_too_long_next = load_too_long;
    head_next          = head;
    fill_next          = fill;
    k_next             = k;
    pos_next           = pos;
    n_next             = n;
    node_next          = node;
    slot_next          = slot;
    done_next          = 1'b0;
    matched_next       = 1'b0;
    status_next        = ST_OK;
    buf_we             = 1'b0;
    buf_re             = 1'b0;
    buf_raddr          = k;
    ring_we            = 1'b0;
    ring_re            = 1'b0;
    ring_raddr         = pos;
    child_we           = 1'b0;
    child_re           = 1'b0;
    child_waddr        = slot;
    child_wdata        = {last | e_term, nchild};

    case (state)
      S_CLEAR: begin
        child_we    = 1'b1;
        child_waddr = clr_addr;
        child_wdata = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == SLOT_W'(CHILD_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          if (kind == KIND_QUERY) begin
            ring_we   = 1'b1;
            head_next = head_inc;
            if (fill < LEN_CW'(MAX_WORD_LEN)) begin
              fill_next = fill + 1'b1;
            end
            pos_next   = head;
            n_next     = '0;
            node_next  = '0;
            state_next = S_Q_RING;
          end else begin
            buf_we = store;
            if (!word_end) begin
              load_len_next      = len_eff;
              load_too_long_next = too_eff;
              done_next          = 1'b1;
            end else begin
              load_len_next      = '0;
              load_too_long_next = 1'b0;
              if (too_eff) begin
                done_next   = 1'b1;
                status_next = ST_LONG;
              end else if (len_eff == '0) begin
                done_next = 1'b1;
              end else begin
                k_next     = len_m1[LEN_AW-1:0];
                node_next  = '0;
                state_next = S_INS_BUF;
              end
            end
          end
        end
      end
      S_INS_BUF: begin
        buf_re     = 1'b1;
        state_next = S_INS_SLOT;
      end
      S_INS_SLOT: begin
        child_re   = 1'b1;
        slot_next  = slot_calc;
        state_next = S_INS_CHK;
      end
      S_INS_CHK: begin
        if (alloc && (nodes_in_use >= CNT_W'(TRIE_NODES))) begin
          done_next   = 1'b1;
          status_next = ST_FULL;
          state_next  = S_IDLE;
        end else begin
          child_we  = alloc || last;
          node_next = nchild;
          if (alloc) begin
            nodes_in_use_next = nodes_in_use + 1'b1;
          end
          if (last) begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end else begin
            k_next     = k - 1'b1;
            buf_re     = 1'b1;
            buf_raddr  = k - 1'b1;
            state_next = S_INS_SLOT;
          end
        end
      end
      S_Q_RING: begin
        ring_re    = 1'b1;
        state_next = S_Q_SLOT;
      end
      S_Q_SLOT: begin
        if (sym >= CHAR_W'(ALPHABET_SIZE)) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          child_re   = 1'b1;
          slot_next  = slot_calc;
          state_next = S_Q_CHK;
        end
      end
      S_Q_CHK: begin
        node_next = e_child;
        n_next    = n_inc;
        if (alloc) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if (e_term) begin
          done_next    = 1'b1;
          matched_next = 1'b1;
          state_next   = S_IDLE;
        end else if (n_inc == fill) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          pos_next   = pos_dec;
          ring_re    = 1'b1;
          ring_raddr = pos_dec;
          state_next = S_Q_SLOT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      nodes_in_use  <= CNT_W'(1);
      load_len      <= '0;
      load_too_long <= 1'b0;
      head          <= '0;
      fill          <= '0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      clr_addr      <= clr_addr_next;
      nodes_in_use  <= nodes_in_use_next;
      load_len      <= load_len_next;
      load_too_long <= load_too_long_next;
      head          <= head_next;
      fill          <= fill_next;
      done          <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    k       <= k_next;
    pos     <= pos_next;
    n       <= n_next;
    node    <= node_next;
    slot    <= slot_next;
    matched <= matched_next;
    status  <= status_next;
  end

  // load word buffer
  ssdm_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(MAX_WORD_LEN)
  ) u_load_buf (
    .clk  (clk),
    .we   (buf_we),
    .waddr(load_len[LEN_AW-1:0]),
    .wdata(char_code),
    .re   (buf_re),
    .raddr(buf_raddr),
    .rdata(buf_rdata)
  );

  // recent stream letters
  ssdm_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(MAX_WORD_LEN)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(head),
    .wdata(char_code),
    .re   (ring_re),
    .raddr(ring_raddr),
    .rdata(ring_rdata)
  );

  // child slots, top bit marks the child as a word end
  ssdm_ram #(
    .WIDTH(NODE_W + 1),
    .DEPTH(CHILD_DEPTH)
  ) u_child (
    .clk  (clk),
    .we   (child_we),
    .waddr(child_waddr),
    .wdata(child_wdata),
    .re   (child_re),
    .raddr(slot_calc),
    .rdata(child_rdata)
  );

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !done)
    else $error("result during clearing pass");

  a_match_status_ok: assert property (@(posedge clk) disable iff (rst)
    (done && matched) |-> (status == ST_OK))
    else $error("match with nonzero status");

  a_node_count_range: assert property (@(posedge clk) disable iff (rst)
    (nodes_in_use >= CNT_W'(1)) && (nodes_in_use <= CNT_W'(TRIE_NODES)))
    else $error("node count out of range");

  a_plain_letter_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (acc && (kind == KIND_LOAD) && !word_end) |=> (done && !matched && !busy))
    else $error("plain load letter not answered next cycle");

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssdm_pkg::*;

  localparam int NODES         = DEF_TRIE_NODES;
  localparam int WORD_MAX      = DEF_MAX_WORD_LEN;
  localparam int ALPHA         = DEF_ALPHABET_SIZE;
  localparam int CODE_TOP      = (1 << CHAR_W) - 1;
  localparam int DICT_SLOTS    = 64;
  localparam int DICT_WORD_MAX = 8;

  typedef struct packed {
    logic                matched;
    logic [STATUS_W-1:0] status;
  } reply_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                kind;
  logic [CHAR_W-1:0]   char_code;
  logic                word_end;
  logic                busy;
  logic                done;
  logic                matched;
  logic [STATUS_W-1:0] status;

  stream_suffix_dictionary_matcher u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .kind      (kind),
    .char_code (char_code),
    .word_end  (word_end),
    .busy      (busy),
    .done      (done),
    .matched   (matched),
    .status    (status)
  );

  // own copy of the trie, load buffer and query history
  int unsigned     trie_next [NODES*ALPHA];
  bit              trie_term [NODES];
  int unsigned     trie_used = 1;
  bit [CHAR_W-1:0] word_buf [WORD_MAX];
  int unsigned     word_len;
  bit              word_dropped;
  bit [CHAR_W-1:0] hist [WORD_MAX];
  int unsigned     hist_head;
  int unsigned     hist_fill;
  reply_t          replies_due [$];
  int              errors;

  // sender pacing and remembered words
  int              sent_count;
  int              burst_left;
  bit              gaps_on;
  bit [CHAR_W-1:0] dict_txt [DICT_SLOTS][DICT_WORD_MAX];
  int              dict_len [DICT_SLOTS];
  int              dict_count;
  int              dict_wr;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // insert the buffered word last letter first
  function automatic logic [STATUS_W-1:0] graft_word();
    int unsigned node;
    int unsigned slot;
    int          k;
    node = 0;
    for (k = int'(word_len) - 1; k >= 0; k--) begin
      slot = node * ALPHA + word_buf[k];
      if (trie_next[slot] == 0) begin
        if (trie_used >= NODES) return ST_FULL;
        trie_next[slot] = trie_used;
        trie_used++;
      end
      node = trie_next[slot];
    end
    if (node != 0) trie_term[node] = 1'b1;
    return ST_OK;
  endfunction

  // walk from the newest history letter backwards
  function automatic bit stream_has_word();
    int unsigned node;
    int unsigned nxt;
    int unsigned pos;
    int unsigned n;
    node = 0;
    pos  = hist_head;
    for (n = 0; n < hist_fill; n++) begin
      pos = (pos == 0) ? WORD_MAX - 1 : pos - 1;
      if (hist[pos] >= ALPHA) return 1'b0;
      nxt = trie_next[node * ALPHA + hist[pos]];
      if (nxt == 0) return 1'b0;
      node = nxt;
      if (trie_term[node]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void note_request(logic k, logic [CHAR_W-1:0] c, logic w);
    reply_t r;
    r = '0;
    r.status = ST_OK;
    if (k == KIND_LOAD) begin
      if (c < ALPHA) begin
        if (word_len < WORD_MAX) begin
          word_buf[word_len] = c;
          word_len++;
        end else begin
          word_dropped = 1'b1;
        end
      end
      if (w) begin
        if (word_dropped) r.status = ST_LONG;
        else if (word_len > 0) r.status = graft_word();
        word_len     = 0;
        word_dropped = 1'b0;
      end
    end else begin
      hist[hist_head] = c;
      hist_head = (hist_head + 1 >= WORD_MAX) ? 0 : hist_head + 1;
      if (hist_fill < WORD_MAX) hist_fill++;
      r.matched = stream_has_word();
    end
    replies_due.push_back(r);
  endfunction

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst) begin
      if (start === 1'b1 && busy === 1'b0) note_request(kind, char_code, word_end);
      if (done === 1'b1) begin
        if (replies_due.size() == 0) begin
          errors++;
          $display("%0t: result with none outstanding, matched %0d status %0d",
                   $time, matched, status);
        end else begin
          want = replies_due.pop_front();
          if (matched !== want.matched) begin
            errors++;
            $display("%0t: matched expected %0d actual %0d", $time, want.matched, matched);
          end
          if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          end
        end
      end
    end
  end

  task automatic send_item(logic k, int c, logic w);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    start     <= 1'b1;
    kind      <= k;
    char_code <= CHAR_W'(c);
    word_end  <= w;
    do @(posedge clk); while (busy !== 1'b0);
    sent_count++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic load_run(int len, int ch);
    int i;
    for (i = 0; i < len; i++) send_item(KIND_LOAD, ch, i == len - 1);
  endtask

  task automatic load_random_word(int len, int hi, bit keep);
    int i;
    int slot;
    bit bad_tail;
    int c;
    bad_tail = ($urandom_range(0, 6) == 0);
    slot     = dict_wr;
    keep     = keep && len <= DICT_WORD_MAX;
    for (i = 0; i < len; i++) begin
      c = $urandom_range(0, hi);
      if (keep) dict_txt[slot][i] = CHAR_W'(c);
      send_item(KIND_LOAD, c, (i == len - 1) && !bad_tail);
    end
    // word end carried by a letter that is not stored
    if (bad_tail) send_item(KIND_LOAD, $urandom_range(ALPHA, CODE_TOP), 1'b1);
    if (keep) begin
      dict_len[slot] = len;
      dict_wr = (dict_wr + 1) % DICT_SLOTS;
      if (dict_count < DICT_SLOTS) dict_count++;
    end
  endtask

  task automatic stream_word(int idx, int lead);
    int i;
    repeat (lead) send_item(KIND_QUERY, $urandom_range(0, 3), 1'($urandom_range(0, 1)));
    for (i = 0; i < dict_len[idx]; i++)
      send_item(KIND_QUERY, int'(dict_txt[idx][i]), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_empty_trie();
    send_item(KIND_QUERY, 0, 1'b0);
    send_item(KIND_QUERY, ALPHA - 1, 1'b1);
    send_item(KIND_QUERY, CODE_TOP, 1'b0);
    send_item(KIND_LOAD, CODE_TOP, 1'b1);
    send_item(KIND_LOAD, 0, 1'b1);
    send_item(KIND_QUERY, 0, 1'b0);
  endtask

  task automatic test_short_words();
    send_item(KIND_LOAD, 0, 1'b0);
    send_item(KIND_LOAD, 1, 1'b1);
    send_item(KIND_QUERY, 0, 1'b0);
    send_item(KIND_QUERY, 1, 1'b0);
    // bad letter inside a word is skipped
    send_item(KIND_LOAD, 2, 1'b0);
    send_item(KIND_LOAD, 30, 1'b0);
    send_item(KIND_LOAD, 3, 1'b1);
    send_item(KIND_QUERY, 2, 1'b0);
    send_item(KIND_QUERY, 3, 1'b0);
    // bad query letter stops the walk
    send_item(KIND_QUERY, 2, 1'b0);
    send_item(KIND_QUERY, 30, 1'b0);
    send_item(KIND_QUERY, 3, 1'b0);
    send_item(KIND_LOAD, ALPHA - 1, 1'b0);
    send_item(KIND_LOAD, CODE_TOP, 1'b1);
    send_item(KIND_QUERY, ALPHA - 1, 1'b0);
  endtask

  task automatic test_longest_word();
    load_run(WORD_MAX, 24);
    repeat (WORD_MAX + 2) send_item(KIND_QUERY, 24, 1'b0);
  endtask

  task automatic test_overlong_word();
    load_run(WORD_MAX + 1, 23);
    load_run(1, 23);
    send_item(KIND_QUERY, 23, 1'b0);
    load_run(WORD_MAX, 22);
    send_item(KIND_LOAD, CODE_TOP, 1'b1);
    repeat (3) send_item(KIND_QUERY, 22, 1'b0);
  endtask

  task automatic test_random_mix(int count);
    int target;
    int r;
    target = sent_count + count;
    while (sent_count < target) begin
      if ($urandom_range(0, 39) == 0) gaps_on = !gaps_on;
      r = $urandom_range(0, 999);
      if (r < 300) begin
        load_random_word($urandom_range(1, 6), ($urandom_range(0, 4) == 0) ? ALPHA - 1 : 3,
                         1'b1);
      end else if (r < 700 && dict_count > 0) begin
        stream_word($urandom_range(0, dict_count - 1), $urandom_range(0, 3));
      end else if (r < 708) begin
        load_random_word($urandom_range(WORD_MAX + 1, WORD_MAX + 2), ALPHA - 1, 1'b0);
      end else if (r < 750) begin
        send_item(KIND_LOAD, $urandom_range(ALPHA, CODE_TOP), 1'b1);
      end else begin
        send_item(1'($urandom_range(0, 1)), $urandom_range(0, CODE_TOP),
                  1'($urandom_range(0, 1)));
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_table_full();
    while (trie_used < NODES) load_random_word(WORD_MAX, ALPHA - 1, 1'b0);
    repeat (4) load_random_word($urandom_range(2, 5), ALPHA - 1, 1'b0);
    if (dict_count > 0) begin
      repeat (6) stream_word($urandom_range(0, dict_count - 1), $urandom_range(0, 2));
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    kind       = KIND_LOAD;
    char_code  = '0;
    word_end   = 1'b0;
    gaps_on    = 1'b1;
    burst_left = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_trie();
    test_short_words();
    test_longest_word();
    test_overlong_word();
    test_random_mix(100);
    test_table_full();
    test_random_mix(30);

    @(negedge clk);
    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (2 * WORD_MAX + 20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
